// ===== rtl/sha256_pkg.sv =====
// ---------------------------------------------------------------------------
// sha256_pkg
// shared constants, types and round functions for the sha-256 core
// ---------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  // one classified word passed from front to back
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } sha_word_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha256_front.sv =====
// ---------------------------------------------------------------------------
// sha256_front
// input stage: clamps the byte count and queues words for the engine
// ---------------------------------------------------------------------------
module sha256_front
  import sha256_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sha_word_t in_word,
  output logic      q_valid,
  input  logic      q_ready,
  output sha_word_t q_word
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_word_t          slots [DEPTH];
  logic [AW-1:0]      wr_ptr, rd_ptr;
  logic [AW:0]        count;
  logic               push, pop;
  sha_word_t          clamped;

  always_comb begin
    clamped = in_word;
    if (in_word.nbytes > 3'd4) clamped.nbytes = 3'd4;
  end

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_word   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= clamped;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== rtl/sha256_engine.sv =====
// ---------------------------------------------------------------------------
// sha256_engine
// byte packer, padding sequencer and one-round-per-cycle compression
// ---------------------------------------------------------------------------
module sha256_engine
  import sha256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  output logic         q_ready,
  input  sha_word_t    q_word,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [255:0] out_digest
);
  typedef enum logic [2:0] {
    S_TAKE, S_BYTES, S_PAD, S_LEN, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t      state, ret_state;
  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [63:0] byte_count;
  logic [5:0]  pos;
  logic [5:0]  round;
  logic [2:0]  idx;
  sha_word_t   cur;
  logic [63:0] bits;

  logic [7:0]  byte_val;
  logic [31:0] wt, x15, x2, s0g, s1g, t1, t2, s1, s0, ch, mj;
  logic [3:0]  ri;

  assign q_ready = (state == S_TAKE);
  assign bits    = {byte_count[60:0], 3'b000};

  always_comb begin
    priority case (state)
      S_BYTES: byte_val = cur.data[31 - 8*idx[1:0] -: 8];
      S_PAD:   byte_val = (idx == 3'd0) ? PAD_BYTE : 8'h00;
      default: byte_val = bits[63 - 8*idx -: 8];
    endcase
  end

  always_comb begin
    ri  = round[3:0];
    x15 = w[ri + 4'd1];
    x2  = w[ri + 4'd14];
    s0g = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
    s1g = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
    wt  = (round < 6'd16) ? w[ri] : w[ri] + s0g + w[ri + 4'd9] + s1g;
    s1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + s1 + ch + round_k(round) + wt;
    s0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    mj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_TAKE;
      out_valid  <= 1'b0;
      byte_count <= '0;
      pos        <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[255 - 32*i -: 32];
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_TAKE: begin
          if (q_valid && q_ready) begin
            cur <= q_word;
            idx <= '0;
            if (q_word.nbytes != 3'd0)  state <= S_BYTES;
            else if (q_word.last)       state <= S_PAD;
          end
        end
        S_BYTES, S_PAD, S_LEN: begin
          w[pos[5:2]][31 - 8*pos[1:0] -: 8] <= byte_val;
          pos <= pos + 6'd1;
          idx <= idx + 3'd1;
          if (state == S_BYTES) byte_count <= byte_count + 64'd1;
          priority if (state == S_BYTES) begin
            if (idx + 3'd1 == cur.nbytes) begin
              ret_state <= cur.last ? S_PAD : S_TAKE;
              idx       <= '0;
              if (pos != 6'd63) state <= cur.last ? S_PAD : S_TAKE;
            end else ret_state <= S_BYTES;
          end else if (state == S_PAD) begin
            if (pos + 6'd1 == LEN_POS) begin
              ret_state <= S_LEN;
              if (pos != 6'd63) begin
                state <= S_LEN;
                idx   <= '0;
              end
            end else begin
              // marker byte is out, the rest of the padding is zeros
              ret_state <= S_PAD;
              idx       <= 3'd1;
            end
          end else begin
            ret_state <= (idx == 3'd7) ? S_OUT : S_LEN;
          end
          if (pos == 6'd63) begin
            state <= S_ROUND;
            round <= '0;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
          end
        end
        S_ROUND: begin
          if (round >= 6'd16) w[ri] <= wt;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          state <= ret_state;
        end
        S_OUT: begin
          if (!out_valid) begin
            for (int i = 0; i < 8; i++) out_digest[255 - 32*i -: 32] <= h[i];
            for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[255 - 32*i -: 32];
            out_valid  <= 1'b1;
            byte_count <= '0;
            pos        <= '0;
            state      <= S_TAKE;
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end
endmodule

// ===== rtl/sha256_message_digest_core.sv =====
// ---------------------------------------------------------------------------
// sha256_message_digest_core
// streaming sha-256 hasher with padding and 256-bit digest output
// ---------------------------------------------------------------------------
// Words enter through a small queue and are packed byte by byte into a
// 64-byte block (one byte per cycle, waiting on the queue between words);
// each full block runs 64 rounds at one round per cycle and then folds the
// result into the hash. Each word is first taken from the queue and then
// has its bytes packed. The final word adds the padding and length bytes
// and one or two compressions before the digest word appears; the queue
// keeps accepting words while it has room and the engine is busy, and the
// engine goes on with the next message while a digest word waits on the
// output, but holds the next digest until the waiting one is taken.
module sha256_message_digest_core
  import sha256_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // message_word[31:0], word_bytes[34:32], zero fill
  input  logic         s_axis_tlast,   // last_word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // digest_top, upper_mid, lower_mid, bottom from low
);
  sha_word_t    in_word, q_word;
  logic         q_valid, q_ready;
  logic [255:0] digest;

  assign in_word.data   = s_axis_tdata[31:0];
  assign in_word.nbytes = s_axis_tdata[34:32];
  assign in_word.last   = s_axis_tlast;

  sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_word(in_word),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  sha256_engine u_engine (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_digest(digest)
  );

  // digest_top sits in the lowest 64 bits
  assign m_axis_tdata = {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};
endmodule
